// ===== rtl/clpc_pkg.sv =====
// Shared types and constants of the control line pulse controller.
package clpc_pkg;

    localparam int LINES     = 8;
    localparam int LINE_W    = 3;
    localparam int PIN_W     = 8;
    localparam int PULSE_MIN = 1;
    localparam int PULSE_MAX = 10000;
    localparam int US_PER_MS = 1000;
    localparam int PLEN_W    = 26;

    typedef enum logic [2:0] {
        CMD_CONFIG = 3'd0,
        CMD_SET    = 3'd1,
        CMD_PULSE  = 3'd2,
        CMD_POLL   = 3'd3,
        CMD_SAFE   = 3'd4,
        CMD_EPOCH  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_NOCFG   = 3'd2,
        ST_FAULT   = 3'd3,
        ST_PENDING = 3'd4,
        ST_NONE    = 3'd5,
        ST_DONE    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        DRV_LOW  = 2'd0,
        DRV_HIGH = 2'd1,
        DRV_HIZ  = 2'd2
    } drv_t;

    // Per-line attributes; the configured flag is kept apart as a bit vector.
    typedef struct packed {
        logic pp;
        logic act;
        logic idle;
    } line_attr_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } clpc_ctl_t;

endpackage

// ===== rtl/clpc_ctrl.sv =====
// Sequencer: capture a command word, execute it, hand the result to the output register.
module clpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output clpc_pkg::clpc_ctl_t  ctl
);
    import clpc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        ctl.capture    = (state_reg == S_IDLE) && req_valid;
        ctl.exec       = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.capture)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (ctl.exec)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/clpc_dp.sv =====
// Datapath: captured command, line state, pulse timer and result register.
module clpc_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  clpc_pkg::clpc_ctl_t          ctl,
    input  logic [2:0]                   cmd,
    input  logic [7:0]                   channel,
    input  logic [1:0]                   mode,
    input  logic [1:0]                   act_level,
    input  logic                         rest_level_set,
    input  logic [1:0]                   rest_level,
    input  logic [1:0]                   target_state,
    input  logic [15:0]                  pulse_width_ms,
    input  logic [63:0]                  now_us,
    input  logic                         port_fault,
    output logic [2:0]                   status,
    output logic [clpc_pkg::PIN_W-1:0]   pin_enable,
    output logic [clpc_pkg::PIN_W-1:0]   pin_data,
    output logic                         line_configured,
    output logic                         pulse_running
);
    import clpc_pkg::*;

    typedef struct packed {
        logic [PIN_W-1:0] en;
        logic [PIN_W-1:0] dat;
        logic             ok;
    } drive_res_t;

    // Captured command word
    logic [2:0]  cmd_reg;
    logic [7:0]  ch_reg;
    logic [1:0]  mode_reg;
    logic [1:0]  act_reg;
    logic        has_idle_reg;
    logic [1:0]  idle_reg;
    logic [1:0]  tgt_reg;
    logic [15:0] pms_reg;
    logic [63:0] now_reg;
    logic        fault_reg;

    // Line and pulse state
    line_attr_t           attr_reg [LINES];
    logic [LINES-1:0]     on_reg, on_next;
    logic [PIN_W-1:0]     en_reg, en_next;
    logic [PIN_W-1:0]     dat_reg, dat_next;
    logic                 busy_reg, busy_next;
    logic [LINE_W-1:0]    pline_reg, pline_next;
    logic [63:0]          pstart_reg, pstart_next;
    logic [PLEN_W-1:0]    plen_reg, plen_next;

    // Result register
    status_t              status_reg, status_next;
    logic                 lcfg_reg, lcfg_next;

    logic                 ch_ok;
    logic [LINE_W-1:0]    ln;
    logic [LINE_W-1:0]    rd_idx;
    line_attr_t           rd_attr;
    logic                 rd_on;
    line_attr_t           new_attr;
    logic                 attr_we;
    logic                 cfg_ok;
    logic                 pms_ok;
    logic [63:0]          elapsed;
    drive_res_t           drv_res;

    function automatic drive_res_t drive_line(input logic [PIN_W-1:0] en,
                                              input logic [PIN_W-1:0] dat,
                                              input logic [LINE_W-1:0] idx,
                                              input drv_t drv,
                                              input logic fault);
        drive_res_t r;
        r.en      = en;
        r.dat     = dat;
        r.en[idx] = 1'b0;
        r.ok      = !fault;
        if (!fault)
        begin
            r.dat[idx] = (drv == DRV_HIGH);
            if (drv != DRV_HIZ)
                r.en[idx] = 1'b1;
        end
        return r;
    endfunction

    function automatic drv_t drive_for(input line_attr_t a, input logic active);
        drv_t d;
        logic lvl;
        lvl = active ? a.act : a.idle;
        if (!a.pp && !active)
            d = DRV_HIZ;
        else
            d = lvl ? DRV_HIGH : DRV_LOW;
        return d;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg      <= cmd;
            ch_reg       <= channel;
            mode_reg     <= mode;
            act_reg      <= act_level;
            has_idle_reg <= rest_level_set;
            idle_reg     <= rest_level;
            tgt_reg      <= target_state;
            pms_reg      <= pulse_width_ms;
            now_reg      <= now_us;
            fault_reg    <= port_fault;
        end
        if (ctl.exec)
        begin
            status_reg <= status_next;
            lcfg_reg   <= lcfg_next;
        end
    end

    always_comb
    begin
        ch_ok   = ch_reg < 8'(LINES);
        ln      = ch_ok ? ch_reg[LINE_W-1:0] : '0;
        rd_idx  = (cmd_reg == CMD_POLL) ? pline_reg : ln;
        rd_attr = attr_reg[rd_idx];
        rd_on   = on_reg[rd_idx];

        new_attr.pp   = (mode_reg == 2'd1);
        new_attr.act  = act_reg[0];
        new_attr.idle = (mode_reg == 2'd1) ? idle_reg[0] : 1'b0;

        if (act_reg > 2'd1)
            cfg_ok = 1'b0;
        else if (mode_reg == 2'd0)
            cfg_ok = (act_reg == 2'd0) && !has_idle_reg;
        else if (mode_reg != 2'd1 || !has_idle_reg || idle_reg > 2'd1)
            cfg_ok = 1'b0;
        else
            cfg_ok = (act_reg != idle_reg);

        pms_ok  = (pms_reg >= 16'(PULSE_MIN)) && (pms_reg <= 16'(PULSE_MAX));
        elapsed = now_reg - pstart_reg;

        drv_res     = '0;
        on_next     = on_reg;
        en_next     = en_reg;
        dat_next    = dat_reg;
        busy_next   = busy_reg;
        pline_next  = pline_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        attr_we     = 1'b0;
        status_next = ST_INVALID;

        case (cmd_reg)
            CMD_CONFIG:
            begin
                if (ch_ok && cfg_ok)
                begin
                    drv_res = drive_line(en_reg, dat_reg, ln, drive_for(new_attr, 1'b0),
                                         fault_reg);
                    en_next  = drv_res.en;
                    dat_next = drv_res.dat;
                    if (drv_res.ok)
                    begin
                        attr_we     = 1'b1;
                        on_next[ln] = 1'b1;
                        status_next = ST_OK;
                    end
                    else
                        status_next = ST_FAULT;
                end
            end
            CMD_SET:
            begin
                if (ch_ok && tgt_reg <= 2'd1)
                begin
                    if (!rd_on)
                        status_next = ST_NOCFG;
                    else
                    begin
                        drv_res = drive_line(en_reg, dat_reg, ln,
                                             drive_for(rd_attr, tgt_reg == 2'd1), fault_reg);
                        en_next     = drv_res.en;
                        dat_next    = drv_res.dat;
                        status_next = drv_res.ok ? ST_OK : ST_FAULT;
                    end
                end
            end
            CMD_PULSE:
            begin
                if (ch_ok && pms_ok)
                begin
                    if (!rd_on)
                        status_next = ST_NOCFG;
                    else
                    begin
                        drv_res = drive_line(en_reg, dat_reg, ln, drive_for(rd_attr, 1'b1),
                                             fault_reg);
                        en_next  = drv_res.en;
                        dat_next = drv_res.dat;
                        if (drv_res.ok)
                        begin
                            busy_next   = 1'b1;
                            pline_next  = ln;
                            pstart_next = now_reg;
                            plen_next   = PLEN_W'(pms_reg) * PLEN_W'(US_PER_MS);
                            status_next = ST_PENDING;
                        end
                        else
                            status_next = ST_FAULT;
                    end
                end
            end
            CMD_POLL:
            begin
                if (!busy_reg || elapsed < 64'(plen_reg))
                    status_next = ST_NONE;
                else
                begin
                    busy_next = 1'b0;
                    drv_res = drive_line(en_reg, dat_reg, pline_reg,
                                         drive_for(rd_attr, 1'b0), fault_reg);
                    en_next     = drv_res.en;
                    dat_next    = drv_res.dat;
                    status_next = drv_res.ok ? ST_DONE : ST_FAULT;
                end
            end
            CMD_SAFE:
            begin
                if (ch_ok)
                begin
                    if (busy_reg && pline_reg == ln)
                        busy_next = 1'b0;
                    drv_res = drive_line(en_reg, dat_reg, ln, DRV_HIZ, fault_reg);
                    en_next     = drv_res.en;
                    dat_next    = drv_res.dat;
                    status_next = drv_res.ok ? ST_OK : ST_FAULT;
                end
            end
            CMD_EPOCH:
            begin
                busy_next   = 1'b0;
                on_next     = '0;
                en_next     = '0;
                dat_next    = fault_reg ? dat_reg : '0;
                status_next = fault_reg ? ST_FAULT : ST_OK;
            end
            default:
                status_next = ST_INVALID;
        endcase

        lcfg_next = ch_ok && on_next[ln];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg     <= '0;
            en_reg     <= '0;
            dat_reg    <= '0;
            busy_reg   <= 1'b0;
            pline_reg  <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            for (int i = 0; i < LINES; i++)
                attr_reg[i] <= '0;
        end
        else if (ctl.exec)
        begin
            on_reg     <= on_next;
            en_reg     <= en_next;
            dat_reg    <= dat_next;
            busy_reg   <= busy_next;
            pline_reg  <= pline_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            if (attr_we)
                attr_reg[ln] <= new_attr;
        end
    end

    // The pin registers already hold the state after the last executed word.
    assign status          = status_reg;
    assign pin_enable      = en_reg;
    assign pin_data        = dat_reg;
    assign line_configured = lcfg_reg;
    assign pulse_running   = busy_reg;

endmodule

// ===== rtl/control_line_pulse_controller_core.sv =====
// Top level of the control line pulse controller: sequencer plus datapath.
//
//   channel   handshake             payload
//   --------  --------------------  -----------------------------------------------
//   request   req_valid/req_ready   cmd channel mode act_level rest_level_set
//                                   rest_level target_state pulse_width_ms now_us
//                                   port_fault
//   response  rsp_valid/rsp_ready   status pin_enable pin_data line_configured
//                                   pulse_running
//
// Each word is captured in the idle state, then executed against the line and pulse
// registers in the execute state; the sequencer runs one word at a time.
// A result waiting in the output register holds the execute step; the next word is
// still captured while it waits.
// Reset is asynchronous, active low, and clears all line, pin and pulse state at once;
// there is no clearing pass.
// Pulse expiry compares the 64-bit wrap-around elapsed time against the stored length.
module control_line_pulse_controller_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [2:0]                   cmd,
    input  logic [7:0]                   channel,
    input  logic [1:0]                   mode,
    input  logic [1:0]                   act_level,
    input  logic                         rest_level_set,
    input  logic [1:0]                   rest_level,
    input  logic [1:0]                   target_state,
    input  logic [15:0]                  pulse_width_ms,
    input  logic [63:0]                  now_us,
    input  logic                         port_fault,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [2:0]                   status,
    output logic [clpc_pkg::PIN_W-1:0]   pin_enable,
    output logic [clpc_pkg::PIN_W-1:0]   pin_data,
    output logic                         line_configured,
    output logic                         pulse_running
);
    import clpc_pkg::*;

    clpc_ctl_t ctl;

    // Sequence capture and execute; own the response valid flag.
    clpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctl       (ctl)
    );

    // Hold the line configuration, pin bits and pulse timer; build each result.
    clpc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cmd             (cmd),
        .channel         (channel),
        .mode            (mode),
        .act_level       (act_level),
        .rest_level_set  (rest_level_set),
        .rest_level      (rest_level),
        .target_state    (target_state),
        .pulse_width_ms  (pulse_width_ms),
        .now_us          (now_us),
        .port_fault      (port_fault),
        .status          (status),
        .pin_enable      (pin_enable),
        .pin_data        (pin_data),
        .line_configured (line_configured),
        .pulse_running   (pulse_running)
    );

endmodule

// ===== rtl/clpc_checker.sv =====
// Port-level checks of the control line pulse controller, bound to the top level.
module clpc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  logic [2:0]                   status,
    input  logic [clpc_pkg::PIN_W-1:0]   pin_enable,
    input  logic [clpc_pkg::PIN_W-1:0]   pin_data,
    input  logic                         pulse_running
);
    import clpc_pkg::*;

    // A stalled response word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(pin_enable) && $stable(pin_data))
        else $error("response word changed while stalled");

    // A captured word blocks the request side during its execute state.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted during execute");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status != 3'd7)
        else $error("undefined status code");

    a_pending_runs: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_PENDING |-> pulse_running)
        else $error("pulse pending but not running");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_DONE |-> !pulse_running)
        else $error("pulse done but still running");

endmodule

bind control_line_pulse_controller_core clpc_checker u_clpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .pin_enable    (pin_enable),
    .pin_data      (pin_data),
    .pulse_running (pulse_running)
);
